>>> sv/mm2h_pkg.sv
package mm2h_pkg;

  localparam logic [31:0] MixMul     = 32'h5bd1e995;
  localparam logic [31:0] SeedMul    = 32'hdeadbeef;
  localparam int unsigned BlockShift = 24;
  localparam int unsigned FinShiftA  = 13;
  localparam int unsigned FinShiftB  = 15;
  localparam logic [2:0]  FullCount  = 3'd4;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_chunk;
    logic [31:0] key_length;
  } in_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic        length_mismatch;
  } out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEED,
    OP_K1,
    OP_K2,
    OP_HMIX,
    OP_TAIL,
    OP_AVAL
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic key_open;
    logic in_full;
    logic in_zero;
    logic in_last;
    logic full;
    logic zero;
    logic last;
    logic out_free;
  } status_t;

  // keep bytes below the count, count of four or more keeps all
  function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
    logic [31:0] m;
    unique case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

>>> sv/mm2h_ctrl.sv
module mm2h_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mm2h_pkg::status_t status_i,
  output mm2h_pkg::cmd_t    cmd_o
);
  import mm2h_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_K1,
    S_K2,
    S_HMIX,
    S_TAIL,
    S_AVAL
  } state_e;

  state_e state_q, state_d;

  function automatic state_e route(input logic full, input logic zero, input logic last);
    state_e s;
    priority if (full) s = S_K1;
    else if (!zero)    s = S_TAIL;
    else if (last)     s = S_AVAL;
    else               s = S_IDLE;
    return s;
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!status_i.key_open) state_d = S_SEED;
          else state_d = route(status_i.in_full, status_i.in_zero, status_i.in_last);
        end
      end
      S_SEED: state_d = route(status_i.full, status_i.zero, status_i.last);
      S_K1:   state_d = S_K2;
      S_K2:   state_d = S_HMIX;
      S_HMIX: state_d = status_i.last ? S_AVAL : S_IDLE;
      S_TAIL: state_d = status_i.last ? S_AVAL : S_IDLE;
      S_AVAL: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    unique case (state_q)
      S_SEED:  cmd_o.op = OP_SEED;
      S_K1:    cmd_o.op = OP_K1;
      S_K2:    cmd_o.op = OP_K2;
      S_HMIX:  cmd_o.op = OP_HMIX;
      S_TAIL:  cmd_o.op = OP_TAIL;
      // hold the avalanche until the output register can take it
      S_AVAL:  cmd_o.op = status_i.out_free ? OP_AVAL : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> sv/mm2h_datapath.sv
module mm2h_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mm2h_pkg::in_t     in_data_i,
  input  mm2h_pkg::cmd_t    cmd_i,
  output mm2h_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mm2h_pkg::out_t    out_data_o
);
  import mm2h_pkg::*;

  logic [31:0] hash_q, hash_d;
  logic [31:0] k_q, k_d;
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic        last_q;
  logic [31:0] stated_q;
  logic [31:0] seen_q;
  logic        err_q;
  logic        open_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [2:0]  in_cnt;
  logic        in_over;
  logic [31:0] mul_a, mul_b, prod;

  assign in_over = (in_data_i.byte_count > FullCount);
  assign in_cnt  = in_over ? FullCount : in_data_i.byte_count;

  // one shared multiplier, low word only
  always_comb begin
    mul_b = MixMul;
    unique case (cmd_i.op)
      OP_SEED: begin
        mul_a = stated_q;
        mul_b = SeedMul;
      end
      OP_K1:   mul_a = word_q;
      OP_K2:   mul_a = k_q ^ (k_q >> BlockShift);
      OP_HMIX: mul_a = hash_q;
      OP_TAIL: mul_a = hash_q ^ (word_q & tail_mask(cnt_q));
      OP_AVAL: mul_a = hash_q ^ (hash_q >> FinShiftA);
      default: mul_a = hash_q;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    hash_d = hash_q;
    k_d    = k_q;
    unique case (cmd_i.op)
      OP_SEED: hash_d = prod ^ stated_q;
      OP_K1:   k_d    = prod;
      OP_K2:   k_d    = prod;
      OP_HMIX: hash_d = prod ^ k_q;
      OP_TAIL: hash_d = prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    k_q    <= k_d;
    if (cmd_i.load) begin
      word_q <= in_data_i.data_word;
      cnt_q  <= in_cnt;
      last_q <= in_data_i.last_chunk;
    end
    if (cmd_i.op == OP_AVAL) begin
      out_q.hash_value      <= prod ^ (prod >> FinShiftB);
      out_q.length_mismatch <= err_q || (seen_q != stated_q);
    end
  end

  // key bookkeeping is settled at the transfer; the mix steps follow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      err_q       <= 1'b0;
      seen_q      <= '0;
      stated_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        open_q   <= 1'b1;
        seen_q   <= (open_q ? seen_q : 32'd0) + {29'd0, in_cnt};
        err_q    <= (open_q && err_q) || in_over ||
                    ((in_cnt != FullCount) && !in_data_i.last_chunk);
        if (!open_q) stated_q <= in_data_i.key_length;
      end
      if (cmd_i.op == OP_AVAL) begin
        open_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.key_open = open_q;
    status_o.in_full  = (in_cnt == FullCount);
    status_o.in_zero  = (in_cnt == 3'd0);
    status_o.in_last  = in_data_i.last_chunk;
    status_o.full     = (cnt_q == FullCount);
    status_o.zero     = (cnt_q == 3'd0);
    status_o.last     = last_q;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/murmur2_key_hash_stream.sv
// Streaming 32-bit MurmurHash2 of a key sent as little-endian chunks of up to four
// bytes, seed 0xdeadbeef times the key length taken from the first chunk. One hash
// and a length-mismatch flag come out per key after the chunk marked last. All
// products run through one shared 32x32 multiplier, one per cycle while nothing
// holds the avalanche: a full block runs k, k again and the hash mix, a short tail
// the tail mix, an empty chunk none, plus the seed on a key's first chunk and the
// avalanche on its last. The result sits in an output register, so the next chunk
// is taken while it waits; the avalanche waits only when that register is still full.
module murmur2_key_hash_stream (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mm2h_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mm2h_pkg::out_t   out_data_o
);
  import mm2h_pkg::*;

  cmd_t    cmd;
  status_t status;

  mm2h_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mm2h_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
